[hw/rtl/artnet_universe_dispatch_defines.svh]
// assertion macros shared by the dispatch block
`ifndef ARTNET_UNIVERSE_DISPATCH_DEFINES_SVH
`define ARTNET_UNIVERSE_DISPATCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AUD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define AUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/aud_pkg.sv]
// shared types, constants and helpers of the universe dispatch block
package aud_pkg;

	localparam int NODES_DEF = 16;
	localparam int NODES_MAX = 64;
	localparam int NET_W     = 7;
	localparam int SUB_W     = 4;
	localparam int UNI_W     = 7;
	localparam int NPORTS    = 4;
	localparam int PORTS_W   = UNI_W * NPORTS;
	localparam int ADDR_W    = 15;
	localparam int DEV_W     = 4;
	localparam int SEQ_W     = 8;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// one net / subnet / four-universe set
	typedef struct packed {
		logic [NET_W-1:0]   net;
		logic [SUB_W-1:0]   subnet;
		logic [PORTS_W-1:0] ports;
	} uniset_t;

	// one table entry as stored
	typedef struct packed {
		logic    map_en;
		uniset_t remap;
		uniset_t route;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic write_entry;
		logic start_scan;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic pend_valid;
		logic out_free;
		logic scan_end;
	} stat_t;

	// sequence step, 255 wraps to 1, zero steps to 1
	function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
		logic [SEQ_W-1:0] n;
		n = s + SEQ_W'(1);
		if (n == '0) begin
			n = SEQ_W'(1);
		end
		return n;
	endfunction

endpackage

[hw/rtl/artnet_universe_dispatch.sv]
// Art-Net universe dispatch table: top level with controller, datapath and checks
// A write word loads one node entry and gives no result. A dispatch word scans
// slots 0 to NODES-1, one slot per cycle unless a hit waits for a busy output register,
// through the single read port of the entry and sequence memories. Each matching
// node gives one result word in slot order, carrying its slot, the translated port
// address and its sequence number, which then steps and wraps 255 to 1; a dispatch
// with no match gives one word with matched low. The last word of each dispatch has
// last set. No word is taken on req while a scan runs. Reset clears the slot valid
// bits at once; no clearing pass is needed.
module artnet_universe_dispatch #(
	parameter int NODES = aud_pkg::NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [aud_pkg::DEV_W-1:0]     entry_index,
	input  logic                          entry_valid,
	input  logic                          map_enable,
	input  logic [aud_pkg::NET_W-1:0]     node_net,
	input  logic [aud_pkg::SUB_W-1:0]     node_subnet,
	input  logic [aud_pkg::PORTS_W-1:0]   node_ports,
	input  logic [aud_pkg::NET_W-1:0]     remap_net,
	input  logic [aud_pkg::SUB_W-1:0]     remap_subnet,
	input  logic [aud_pkg::PORTS_W-1:0]   remap_ports,
	input  logic [aud_pkg::ADDR_W-1:0]    port_address,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          matched,
	output logic [aud_pkg::DEV_W-1:0]     device_index,
	output logic [aud_pkg::ADDR_W-1:0]    send_address,
	output logic [aud_pkg::SEQ_W-1:0]     sequence_res,
	output logic                          last
);

`include "artnet_universe_dispatch_defines.svh"

	aud_pkg::cmd_t  cmd;
	aud_pkg::stat_t stat;

	// scan sequencer
	aud_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (op),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// table and result path
	aud_dpath #(
		.NODES (NODES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.entry_index  (entry_index),
		.entry_valid  (entry_valid),
		.map_enable   (map_enable),
		.node_net     (node_net),
		.node_subnet  (node_subnet),
		.node_ports   (node_ports),
		.remap_net    (remap_net),
		.remap_subnet (remap_subnet),
		.remap_ports  (remap_ports),
		.port_address (port_address),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.matched      (matched),
		.device_index (device_index),
		.send_address (send_address),
		.sequence_res (sequence_res),
		.last         (last)
	);

	// checks
	`AUD_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0(cmd), "controller issued two commands")
	`AUD_ASSERT_NOW(a_push_free, cmd.step && stat.hit && stat.pend_valid, stat.out_free, "hit pushed into busy output")
	`AUD_ASSERT_NEXT(a_finish_last, cmd.finish, res_valid && last, "final word missing last mark")
	`AUD_ASSERT_NOW(a_start_clean, cmd.start_scan, !stat.pend_valid, "scan started with a pending hit")

endmodule

[hw/rtl/aud_ctrl.sv]
// scan controller: accepts words, sequences the table scan and final result
module aud_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          op,
	output logic          req_stall,
	output aud_pkg::cmd_t cmd,
	input  aud_pkg::stat_t stat
);

	aud_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aud_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			aud_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (op == aud_pkg::OP_WRITE) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.start_scan = 1'b1;
						state_d        = aud_pkg::ST_SCAN;
					end
				end
			end
			aud_pkg::ST_SCAN: begin
				// hold the slot while a new hit needs the busy output register
				if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
					cmd.step = 1'b1;
					if (stat.scan_end) begin
						state_d = aud_pkg::ST_DONE;
					end
				end
			end
			aud_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = aud_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aud_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/aud_dpath.sv]
// datapath: entry table, sequence memory, match logic, pending and output registers
module aud_dpath #(
	parameter int NODES = aud_pkg::NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aud_pkg::cmd_t                 cmd,
	output aud_pkg::stat_t                stat,
	input  logic [aud_pkg::DEV_W-1:0]     entry_index,
	input  logic                          entry_valid,
	input  logic                          map_enable,
	input  logic [aud_pkg::NET_W-1:0]     node_net,
	input  logic [aud_pkg::SUB_W-1:0]     node_subnet,
	input  logic [aud_pkg::PORTS_W-1:0]   node_ports,
	input  logic [aud_pkg::NET_W-1:0]     remap_net,
	input  logic [aud_pkg::SUB_W-1:0]     remap_subnet,
	input  logic [aud_pkg::PORTS_W-1:0]   remap_ports,
	input  logic [aud_pkg::ADDR_W-1:0]    port_address,
	input  logic                          res_stall,
	output logic                          res_valid,
	output logic                          matched,
	output logic [aud_pkg::DEV_W-1:0]     device_index,
	output logic [aud_pkg::ADDR_W-1:0]    send_address,
	output logic [aud_pkg::SEQ_W-1:0]     sequence_res,
	output logic                          last
);

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

	// storage
	aud_pkg::entry_t              entry_mem [NODES];
	logic [aud_pkg::SEQ_W-1:0]    seq_mem   [NODES];
	logic [NODES-1:0]             slot_valid_q;

	aud_pkg::entry_t              entry_rd_q;
	logic [aud_pkg::SEQ_W-1:0]    seq_rd_q;
	logic [IW-1:0]                idx_q;
	logic [aud_pkg::ADDR_W-1:0]   addr_q;

	logic                         pend_valid_q;
	logic [aud_pkg::DEV_W-1:0]    pend_dev_q;
	logic [aud_pkg::ADDR_W-1:0]   pend_send_q;
	logic [aud_pkg::SEQ_W-1:0]    pend_seq_q;

	logic                         res_valid_q;
	logic                         res_matched_q;
	logic [aud_pkg::DEV_W-1:0]    res_dev_q;
	logic [aud_pkg::ADDR_W-1:0]   res_send_q;
	logic [aud_pkg::SEQ_W-1:0]    res_seq_q;
	logic                         res_last_q;

	// write address decode
	logic [6:0]                   wr_ext;
	logic [IW-1:0]                wr_addr;
	logic                         wr_in_range;
	logic                         do_write;

	assign wr_ext      = 7'(entry_index);
	assign wr_addr     = wr_ext[IW-1:0];
	assign wr_in_range = wr_ext < 7'(NODES);
	assign do_write    = cmd.write_entry && wr_in_range;

	// read address: slot 0 on start, next slot on each step
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	assign stat.scan_end = (idx_q == IW'(NODES - 1));
	assign rd_en         = cmd.start_scan || (cmd.step && !stat.scan_end);
	assign rd_addr       = cmd.start_scan ? '0 : idx_q + IW'(1);

	// entry table
	aud_pkg::entry_t wr_entry;

	assign wr_entry.map_en       = map_enable;
	assign wr_entry.route.net    = node_net;
	assign wr_entry.route.subnet = node_subnet;
	assign wr_entry.route.ports  = node_ports;
	assign wr_entry.remap.net    = remap_net;
	assign wr_entry.remap.subnet = remap_subnet;
	assign wr_entry.remap.ports  = remap_ports;

	always_ff @(posedge clk) begin
		if (do_write) begin
			entry_mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			entry_rd_q <= entry_mem[rd_addr];
		end
	end

	// match the current slot against the dispatched address
	aud_pkg::uniset_t           act;
	logic                       set_match;
	logic                       port_hit;
	logic [1:0]                 hit_pos;
	logic [aud_pkg::UNI_W-1:0]  rt_port;
	logic [3:0]                 send_uni;
	logic [aud_pkg::ADDR_W-1:0] send_val;

	always_comb begin
		act       = entry_rd_q.map_en ? entry_rd_q.remap : entry_rd_q.route;
		set_match = (act.net == addr_q[14:8]) && (act.subnet == addr_q[7:4]);
		port_hit  = 1'b0;
		hit_pos   = '0;
		for (int i = aud_pkg::NPORTS - 1; i >= 0; i--) begin
			if (act.ports[aud_pkg::UNI_W*i +: aud_pkg::UNI_W] ==
				aud_pkg::UNI_W'(addr_q[3:0])) begin
				port_hit = 1'b1;
				hit_pos  = 2'(i);
			end
		end
		rt_port  = entry_rd_q.route.ports[aud_pkg::UNI_W*hit_pos +: aud_pkg::UNI_W];
		// unused route port falls back to the remap universe, which equals the address
		send_uni = (rt_port[6:4] == '0) ? rt_port[3:0] : addr_q[3:0];
		send_val = entry_rd_q.map_en ?
			{entry_rd_q.route.net, entry_rd_q.route.subnet, send_uni} : addr_q;
	end

	assign stat.hit = slot_valid_q[idx_q] && set_match && port_hit;

	// sequence memory, one write port shared by table writes and hits
	logic                      seq_we;
	logic [IW-1:0]             seq_waddr;
	logic [aud_pkg::SEQ_W-1:0] seq_wdata;
	logic                      take_hit;

	assign take_hit  = cmd.step && stat.hit;
	assign seq_we    = (do_write && !slot_valid_q[wr_addr]) || take_hit;
	assign seq_waddr = cmd.write_entry ? wr_addr : idx_q;
	assign seq_wdata = cmd.write_entry ? aud_pkg::SEQ_W'(1) : aud_pkg::seq_next(seq_rd_q);

	always_ff @(posedge clk) begin
		if (seq_we) begin
			seq_mem[seq_waddr] <= seq_wdata;
		end
		if (rd_en) begin
			seq_rd_q <= seq_mem[rd_addr];
		end
	end

	// scan index and latched address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_q <= rd_addr;
		end
		if (cmd.start_scan) begin
			addr_q <= port_address;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (do_write) begin
			slot_valid_q[wr_addr] <= entry_valid;
		end
	end

	// pending hit, held back until it is known whether it is the last
	logic push_pend;

	assign push_pend       = take_hit && pend_valid_q;
	assign stat.pend_valid = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (take_hit) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.finish || cmd.start_scan) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			pend_dev_q  <= aud_pkg::DEV_W'(idx_q);
			pend_send_q <= send_val;
			pend_seq_q  <= seq_rd_q;
		end
	end

	// output register
	assign stat.out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push_pend || cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			res_matched_q <= 1'b1;
			res_dev_q     <= pend_dev_q;
			res_send_q    <= pend_send_q;
			res_seq_q     <= pend_seq_q;
			res_last_q    <= 1'b0;
		end else if (cmd.finish) begin
			res_matched_q <= pend_valid_q;
			res_dev_q     <= pend_valid_q ? pend_dev_q : '0;
			res_send_q    <= pend_valid_q ? pend_send_q : '0;
			res_seq_q     <= pend_valid_q ? pend_seq_q : '0;
			res_last_q    <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign matched      = res_matched_q;
	assign device_index = res_dev_q;
	assign send_address = res_send_q;
	assign sequence_res = res_seq_q;
	assign last         = res_last_q;

endmodule

[bench/artnet_universe_dispatch_check.sv]
`timescale 1ns / 100ps
// dispatch checker: tracks the node table, predicts result words and compares them
module artnet_universe_dispatch_check
	import aud_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               op,
	input  logic [DEV_W-1:0]   entry_index,
	input  logic               entry_valid,
	input  logic               map_enable,
	input  logic [NET_W-1:0]   node_net,
	input  logic [SUB_W-1:0]   node_subnet,
	input  logic [PORTS_W-1:0] node_ports,
	input  logic [NET_W-1:0]   remap_net,
	input  logic [SUB_W-1:0]   remap_subnet,
	input  logic [PORTS_W-1:0] remap_ports,
	input  logic [ADDR_W-1:0]  port_address,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic               matched,
	input  logic [DEV_W-1:0]   device_index,
	input  logic [ADDR_W-1:0]  send_address,
	input  logic [SEQ_W-1:0]   sequence_res,
	input  logic               last,
	output int                 mismatches,
	output int                 words_owed,
	output int                 writes_seen,
	output int                 dispatches_seen,
	output int                 words_checked,
	output int                 misses_seen,
	output int                 wraps_seen,
	output int                 widest
);

	localparam int UNI_ADDR_W = ADDR_W - NET_W - SUB_W;
	localparam int UNI_TOP    = 15;
	localparam int SHOW_MAX   = 40;

	// one expected result word
	typedef struct packed {
		logic              matched;
		logic [DEV_W-1:0]  device;
		logic [ADDR_W-1:0] addr;
		logic [SEQ_W-1:0]  seq;
		logic              last;
	} route_word_t;

	// own copy of the node table
	logic             node_live  [NODES];
	logic             node_remap [NODES];
	uniset_t          node_route [NODES];
	uniset_t          node_alt   [NODES];
	logic [SEQ_W-1:0] node_seq   [NODES];

	route_word_t owed_words[$];
	route_word_t want;

	// one universe of a set, port 0 lowest
	function automatic logic [UNI_W-1:0] port_of(input uniset_t u, input int i);
		return u.ports[UNI_W*i +: UNI_W];
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < SHOW_MAX) begin
			$display("%0t: dispatch mismatch at word %0d: %s", $time, words_checked, msg);
		end
		mismatches++;
	endtask

	// scan the table for one port address and queue the words it should give
	task automatic route_dispatch(input logic [ADDR_W-1:0] a);
		uniset_t          act;
		logic [UNI_W-1:0] uni_out;
		route_word_t      held;
		bit               have;
		int               hit;
		int               n;
		have = 1'b0;
		n    = 0;
		held = '0;
		for (int d = 0; d < NODES; d++) begin
			hit = -1;
			if (node_live[d]) begin
				act = node_remap[d] ? node_alt[d] : node_route[d];
				if (act.net == a[ADDR_W-1 -: NET_W] && act.subnet == a[UNI_ADDR_W +: SUB_W]) begin
					// lowest matching port wins
					for (int i = NPORTS - 1; i >= 0; i--) begin
						if (port_of(act, i) == UNI_W'(a[UNI_ADDR_W-1:0])) begin
							hit = i;
						end
					end
				end
			end
			if (hit >= 0) begin
				if (have) begin
					owed_words.push_back(held);
				end
				held.matched = 1'b1;
				held.device  = DEV_W'(d);
				held.last    = 1'b0;
				// remap sends the route universe, or the remap one where the route port is unused
				if (node_remap[d]) begin
					uni_out = port_of(node_route[d], hit);
					if (uni_out > UNI_TOP) begin
						uni_out = port_of(act, hit);
					end
					held.addr = {node_route[d].net, node_route[d].subnet, uni_out[UNI_ADDR_W-1:0]};
				end else begin
					held.addr = a;
				end
				held.seq    = node_seq[d];
				node_seq[d] = node_seq[d] + 1'b1;
				if (node_seq[d] == '0) begin
					node_seq[d] = SEQ_W'(1);
					wraps_seen++;
				end
				have = 1'b1;
				n++;
			end
		end
		// nothing matched: a single empty word
		if (!have) begin
			held = '0;
			n    = 1;
			misses_seen++;
		end
		held.last = 1'b1;
		owed_words.push_back(held);
		dispatches_seen++;
		if (n > widest) begin
			widest = n;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NODES; d++) begin
				node_live[d]  = 1'b0;
				node_remap[d] = 1'b0;
				node_route[d] = '0;
				node_alt[d]   = '0;
				node_seq[d]   = SEQ_W'(1);
			end
			owed_words.delete();
			mismatches      = 0;
			words_owed      = 0;
			writes_seen     = 0;
			dispatches_seen = 0;
			words_checked   = 0;
			misses_seen     = 0;
			wraps_seen      = 0;
			widest          = 0;
		end else begin
			// accepted result word against the oldest expectation
			if (res_valid && !res_stall) begin
				if (owed_words.size() == 0) begin
					flag_mismatch($sformatf("word for slot %0d with nothing owed", device_index));
				end else begin
					want = owed_words.pop_front();
					if (matched !== want.matched) begin
						flag_mismatch($sformatf("matched %0b, want %0b", matched, want.matched));
					end
					if (device_index !== want.device) begin
						flag_mismatch($sformatf("device_index %0d, want %0d",
							device_index, want.device));
					end
					if (send_address !== want.addr) begin
						flag_mismatch($sformatf("send_address %h, want %h",
							send_address, want.addr));
					end
					if (sequence_res !== want.seq) begin
						flag_mismatch($sformatf("sequence_res %0d, want %0d",
							sequence_res, want.seq));
					end
					if (last !== want.last) begin
						flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
					end
					words_checked++;
				end
			end
			// accepted request word: table write or dispatch
			if (req_valid && !req_stall) begin
				if (op == OP_WRITE) begin
					if (int'(entry_index) < NODES) begin
						if (!node_live[entry_index]) begin
							node_seq[entry_index] = SEQ_W'(1);
						end
						node_live[entry_index]  = entry_valid;
						node_remap[entry_index] = map_enable;
						node_route[entry_index] = {node_net, node_subnet, node_ports};
						node_alt[entry_index]   = {remap_net, remap_subnet, remap_ports};
					end
					writes_seen++;
				end else begin
					route_dispatch(port_address);
				end
			end
			words_owed = owed_words.size();
		end
	end

endmodule

[bench/artnet_universe_dispatch_tb.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, request and result idling, stimulus and verdict
module artnet_universe_dispatch_tb;
	import aud_pkg::*;

	localparam int NODES        = NODES_DEF;
	localparam int RANDOM_WORDS = 310;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 60;
	localparam int UNI_TOP      = 15;
	localparam logic [ADDR_W-1:0] ADDR_ALL = {ADDR_W{1'b1}};

	// one request word as offered
	typedef struct {
		logic              op;
		logic [DEV_W-1:0]  slot;
		logic              live;
		logic              remap;
		uniset_t           route;
		uniset_t           alt;
		logic [ADDR_W-1:0] addr;
	} table_word_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               op;
	logic [DEV_W-1:0]   entry_index;
	logic               entry_valid;
	logic               map_enable;
	logic [NET_W-1:0]   node_net;
	logic [SUB_W-1:0]   node_subnet;
	logic [PORTS_W-1:0] node_ports;
	logic [NET_W-1:0]   remap_net;
	logic [SUB_W-1:0]   remap_subnet;
	logic [PORTS_W-1:0] remap_ports;
	logic [ADDR_W-1:0]  port_address;
	logic               res_valid;
	logic               res_stall;
	logic               matched;
	logic [DEV_W-1:0]   device_index;
	logic [ADDR_W-1:0]  send_address;
	logic [SEQ_W-1:0]   sequence_res;
	logic               last;

	int mismatches;
	int words_owed;
	int writes_seen;
	int dispatches_seen;
	int words_checked;
	int misses_seen;
	int wraps_seen;
	int widest;

	int   cycle_count = 0;
	int   words_sent  = 0;
	int   tx_quiet    = 0;
	int   rx_quiet    = 0;
	logic hold_results;

	// shared address family that most shaped entries answer to
	logic [NET_W-1:0] home_net;
	logic [SUB_W-1:0] home_sub;
	logic [UNI_W-1:0] home_unis [NPORTS];

	// what has been written, used only to aim dispatches
	logic    shadow_live [NODES];
	uniset_t shadow_act  [NODES];

	artnet_universe_dispatch #(
		.NODES(NODES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.map_enable(map_enable),
		.node_net(node_net),
		.node_subnet(node_subnet),
		.node_ports(node_ports),
		.remap_net(remap_net),
		.remap_subnet(remap_subnet),
		.remap_ports(remap_ports),
		.port_address(port_address),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.matched(matched),
		.device_index(device_index),
		.send_address(send_address),
		.sequence_res(sequence_res),
		.last(last)
	);

	artnet_universe_dispatch_check #(
		.NODES(NODES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.map_enable(map_enable),
		.node_net(node_net),
		.node_subnet(node_subnet),
		.node_ports(node_ports),
		.remap_net(remap_net),
		.remap_subnet(remap_subnet),
		.remap_ports(remap_ports),
		.port_address(port_address),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.matched(matched),
		.device_index(device_index),
		.send_address(send_address),
		.sequence_res(sequence_res),
		.last(last),
		.mismatches(mismatches),
		.words_owed(words_owed),
		.writes_seen(writes_seen),
		.dispatches_seen(dispatches_seen),
		.words_checked(words_checked),
		.misses_seen(misses_seen),
		.wraps_seen(wraps_seen),
		.widest(widest)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("artnet_universe_dispatch_tb failed");
			$finish;
		end
	end

	// idle length: mostly none or short, a few long, and now and then a quiet stretch
	function automatic int idle_len(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [PORTS_W-1:0] pack4(input logic [UNI_W-1:0] p0,
		input logic [UNI_W-1:0] p1, input logic [UNI_W-1:0] p2, input logic [UNI_W-1:0] p3);
		return {p3, p2, p1, p0};
	endfunction

	function automatic uniset_t uni(input logic [NET_W-1:0] n, input logic [SUB_W-1:0] s,
		input logic [PORTS_W-1:0] p);
		uniset_t u;
		u.net    = n;
		u.subnet = s;
		u.ports  = p;
		return u;
	endfunction

	// dispatch word; the entry fields carry random filler the block must ignore
	function automatic table_word_t dispatch_word(input logic [ADDR_W-1:0] a);
		table_word_t w;
		w.op    = OP_DISPATCH;
		w.slot  = DEV_W'($urandom);
		w.live  = 1'($urandom);
		w.remap = 1'($urandom);
		w.route = uni(NET_W'($urandom), SUB_W'($urandom), PORTS_W'($urandom));
		w.alt   = uni(NET_W'($urandom), SUB_W'($urandom), PORTS_W'($urandom));
		w.addr  = a;
		return w;
	endfunction

	function automatic table_word_t write_word(input int slot, input logic live,
		input logic remap, input uniset_t route, input uniset_t alt);
		table_word_t w;
		w       = dispatch_word(ADDR_W'($urandom));
		w.op    = OP_WRITE;
		w.slot  = DEV_W'(slot);
		w.live  = live;
		w.remap = remap;
		w.route = route;
		w.alt   = alt;
		return w;
	endfunction

	// entry whose active set mostly answers to the home family
	function automatic table_word_t shaped_write(input int slot);
		table_word_t      w;
		uniset_t          act;
		logic [PORTS_W-1:0] pr;
		logic [UNI_W-1:0] v;
		bit               rotated;
		int               k;
		int               r;
		w        = dispatch_word(ADDR_W'($urandom));
		w.op     = OP_WRITE;
		w.slot   = DEV_W'(slot);
		w.live   = ($urandom_range(0, 9) != 0);
		w.remap  = 1'($urandom);
		act.net    = ($urandom_range(0, 99) < 85) ? home_net : NET_W'($urandom);
		act.subnet = ($urandom_range(0, 99) < 85) ? home_sub : SUB_W'($urandom);
		rotated  = ($urandom_range(0, 3) != 0);
		k        = $urandom_range(0, NPORTS - 1);
		pr       = '0;
		for (int i = 0; i < NPORTS; i++) begin
			r = $urandom_range(0, 99);
			if (rotated && r < 92) v = home_unis[(i + k) % NPORTS];
			else if (r < 60) v = home_unis[$urandom_range(0, NPORTS - 1)];
			else if (r < 80) v = UNI_W'($urandom_range(0, UNI_TOP));
			else v = UNI_W'($urandom_range(UNI_TOP + 1, 127));
			pr[UNI_W*i +: UNI_W] = v;
		end
		act.ports = pr;
		if (w.remap) begin
			// route universes: some used, some unused so the remap one is sent
			w.alt = act;
			for (int i = 0; i < NPORTS; i++) begin
				w.route.ports[UNI_W*i +: UNI_W] = $urandom_range(0, 1) ?
					UNI_W'($urandom_range(0, UNI_TOP)) : UNI_W'($urandom_range(UNI_TOP + 1, 127));
			end
		end else begin
			w.route = act;
		end
		return w;
	endfunction

	// offer one word at a falling edge and hold it until taken
	task automatic send_word(input table_word_t w);
		int gap;
		op           <= w.op;
		entry_index  <= w.slot;
		entry_valid  <= w.live;
		map_enable   <= w.remap;
		node_net     <= w.route.net;
		node_subnet  <= w.route.subnet;
		node_ports   <= w.route.ports;
		remap_net    <= w.alt.net;
		remap_subnet <= w.alt.subnet;
		remap_ports  <= w.alt.ports;
		port_address <= w.addr;
		req_valid    <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		words_sent++;
		if (w.op == OP_WRITE) begin
			shadow_live[w.slot] = w.live;
			shadow_act[w.slot]  = w.remap ? w.alt : w.route;
		end
		@(negedge clk);
		gap = idle_len(tx_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// result side stalls
	initial begin
		int n;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				res_stall <= 1'b1;
			end else begin
				n = idle_len(rx_quiet);
				res_stall <= (n != 0);
				if (n > 1) repeat (n - 1) @(negedge clk);
			end
		end
	end

	// one long hold-off on the result side so the block backs up into its input
	initial begin
		hold_results = 1'b0;
		wait (words_sent >= HOLD_AFTER);
		@(posedge clk);
		hold_results = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results = 1'b0;
	end

	initial begin
		table_word_t      w;
		logic [UNI_W-1:0] pv;
		logic [ADDR_W-1:0] a;
		logic [SUB_W-1:0] base;
		int               r;
		int               s;
		int               k;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		op           = OP_WRITE;
		entry_index  = '0;
		entry_valid  = 1'b0;
		map_enable   = 1'b0;
		node_net     = '0;
		node_subnet  = '0;
		node_ports   = '0;
		remap_net    = '0;
		remap_subnet = '0;
		remap_ports  = '0;
		port_address = '0;
		for (int i = 0; i < NODES; i++) begin
			shadow_live[i] = 1'b0;
			shadow_act[i]  = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table gives one empty word
		send_word(dispatch_word(ADDR_ALL));
		// plain route at the top of the ranges, duplicate ports: lowest wins
		send_word(write_word(0, 1'b1, 1'b0,
			uni(7'd127, 4'd15, pack4(7'd15, 7'd15, 7'd127, 7'd0)), uni('1, '1, '1)));
		send_word(dispatch_word({7'd127, 4'd15, 4'd15}));
		send_word(dispatch_word({7'd127, 4'd15, 4'd0}));
		// remapped node: route universe used, or remap universe where the route one is unused
		send_word(write_word(15, 1'b1, 1'b1,
			uni(7'd0, 4'd0, pack4(7'd127, 7'd3, 7'd16, 7'd0)),
			uni(7'd5, 4'd10, pack4(7'd7, 7'd8, 7'd9, 7'd127))));
		send_word(dispatch_word({7'd5, 4'd10, 4'd7}));
		send_word(dispatch_word({7'd5, 4'd10, 4'd8}));
		send_word(dispatch_word({7'd5, 4'd10, 4'd9}));
		// route set of a remapped node does not match
		send_word(dispatch_word({7'd0, 4'd0, 4'd0}));
		// rewrite of a live slot keeps its sequence
		send_word(write_word(0, 1'b1, 1'b0,
			uni(7'd127, 4'd15, pack4(7'd15, 7'd15, 7'd127, 7'd0)), uni('0, '0, '0)));
		send_word(dispatch_word(ADDR_ALL));
		// slot cleared, then written again: sequence restarts
		send_word(write_word(0, 1'b0, 1'b0,
			uni(7'd127, 4'd15, pack4(7'd15, 7'd15, 7'd127, 7'd0)), uni('0, '0, '0)));
		send_word(dispatch_word(ADDR_ALL));
		send_word(write_word(0, 1'b1, 1'b0,
			uni(7'd127, 4'd15, pack4(7'd15, 7'd15, 7'd127, 7'd0)), uni('0, '0, '0)));
		send_word(dispatch_word(ADDR_ALL));
		// all-zero entry and address
		send_word(write_word(7, 1'b1, 1'b0, uni('0, '0, '0), uni('0, '0, '0)));
		send_word(dispatch_word('0));
		// two nodes on one address, the second through remap with unused route ports
		send_word(write_word(8, 1'b1, 1'b1,
			uni(7'd127, 4'd15, pack4(7'd127, 7'd127, 7'd127, 7'd127)),
			uni(7'd127, 4'd15, pack4(7'd15, 7'd0, 7'd0, 7'd0))));
		send_word(dispatch_word(ADDR_ALL));

		// home family for the random part
		home_net = NET_W'($urandom);
		home_sub = SUB_W'($urandom);
		base     = SUB_W'($urandom);
		for (int i = 0; i < NPORTS; i++) begin
			home_unis[i] = UNI_W'(SUB_W'(base + 4 * i));
		end

		// fill the table, then mostly dispatches aimed at it
		for (int i = 0; i < NODES; i++) begin
			w      = shaped_write(i);
			w.live = 1'b1;
			send_word(w);
		end
		for (int j = NODES; j < RANDOM_WORDS; j++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				w = shaped_write($urandom_range(0, NODES - 1));
			end else if (r < 8) begin
				w = write_word($urandom_range(0, NODES - 1), 1'($urandom), 1'($urandom),
					uni(NET_W'($urandom), SUB_W'($urandom), PORTS_W'($urandom)),
					uni(NET_W'($urandom), SUB_W'($urandom), PORTS_W'($urandom)));
			end else begin
				r = $urandom_range(0, 99);
				a = ADDR_W'($urandom);
				if (r < 80) begin
					a = {home_net, home_sub, home_unis[$urandom_range(0, NPORTS - 1)][SUB_W-1:0]};
				end else if (r < 90) begin
					s  = $urandom_range(0, NODES - 1);
					k  = $urandom_range(0, NPORTS - 1);
					pv = shadow_act[s].ports[UNI_W*k +: UNI_W];
					if (shadow_live[s] && pv <= UNI_TOP) begin
						a = {shadow_act[s].net, shadow_act[s].subnet, pv[SUB_W-1:0]};
					end
				end
				w = dispatch_word(a);
			end
			send_word(w);
		end
		req_valid <= 1'b0;

		// drain, then wait for stray words
		while (words_owed != 0) @(negedge clk);
		repeat (NODES + 8) @(negedge clk);

		$display("covered %0d table writes and %0d dispatches; %0d result words checked, %0d empty",
			writes_seen, dispatches_seen, words_checked, misses_seen);
		$display("sequence counters wrapped %0d times; widest dispatch gave %0d words",
			wraps_seen, widest);
		if (mismatches == 0 && words_owed == 0) begin
			$display("artnet_universe_dispatch_tb passed");
		end else begin
			$display("artnet_universe_dispatch_tb failed");
		end
		$finish;
	end

endmodule
